// ===== src/moving_window_bollinger_bands_defines.svh =====
// Assertion macros shared by the RTL. They compile to nothing in synthesis.
`ifndef MOVING_WINDOW_BOLLINGER_BANDS_DEFINES_SVH
`define MOVING_WINDOW_BOLLINGER_BANDS_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and held off during reset.
`define MWBB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mwbb assertion failed");
// Next-cycle implication, sampled on clk and held off during reset.
`define MWBB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mwbb assertion failed");
`else
`define MWBB_ASSERT_IMP(lbl, ante, cons)
`define MWBB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/mwbb_pkg.sv =====
package mwbb_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int PRICE_BITS_DEF = 24;

  localparam int WLEN_W     = 7;
  localparam int OUT_W      = 24;
  localparam int BAND_W     = 26;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd14;

  // Register index, taken from paddr above the byte offset.
  localparam logic [CFG_ADDR_W-3:0] REG_WINDOW_LEN = 1'b0;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

endpackage

// ===== src/mwbb_ifs.sv =====
interface mwbb_in_if import mwbb_pkg::*; #(
  parameter int PRICE_BITS = PRICE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;
  logic                  restart;

  modport source (output valid, price, restart, input ready);
  modport sink (input valid, price, restart, output ready);
endinterface

interface mwbb_out_if import mwbb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OUT_W-1:0]         mean;
  logic [OUT_W-1:0]         std_dev;
  logic [BAND_W-1:0]        upper_band;
  logic signed [BAND_W-1:0] lower_band;
  logic                     window_full;

  modport source (output valid, mean, std_dev, upper_band, lower_band, window_full,
                  input ready);
  modport sink (input valid, mean, std_dev, upper_band, lower_band, window_full,
                output ready);
endinterface

// ===== src/moving_window_bollinger_bands.sv =====
// Moving-window Bollinger bands over a stream of Q16.8 closing prices.
// in_chan carries one price and a restart flag per transaction; restart empties
// the window before that price is added. out_chan returns one result per input:
// the window mean, the population deviation, mean +/- two deviations, and a
// flag once window_len prices have been collected. window_len is written over
// the APB port at address 0; a write also empties the window.
// Each transaction runs from acceptance through the update, division, squaring,
// variance, square-root and output states before the next acceptance. The time
// goes to the two parallel divisions by the fill count, which retire two
// quotient bits a cycle, and to the floor square root, which retires one root
// bit a cycle. SQW, the width of the running sum of squares, sets the division
// length. Prices live in a ring memory with one read port and one write port,
// both used on the acceptance edge.
// A finished result waits in the output register while the next price is
// already being worked on; only if that one finishes too does the block hold.
// Reset sets window_len to 14 and empties the window; no memory clear is needed.
`include "moving_window_bollinger_bands_defines.svh"

module moving_window_bollinger_bands import mwbb_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mwbb_in_if.sink               in_chan,
  mwbb_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PW     = $clog2(MAX_WINDOW);
  localparam int LW     = $clog2(MAX_WINDOW + 1);
  localparam int SW_RAW = PRICE_BITS + LW;
  localparam int SW     = (SW_RAW > 64) ? 64 : SW_RAW;
  localparam int SQ_RAW = 2 * PRICE_BITS + LW;
  localparam int SQW    = (SQ_RAW > 64) ? 64 : SQ_RAW;
  localparam int DW     = SQW + (SQW % 2);
  localparam int DIT    = DW / 2;
  localparam int VW     = 2 * PRICE_BITS;
  localparam int SIT    = PRICE_BITS;
  localparam int CNT_W  = $clog2(((DIT > SIT) ? DIT : SIT) + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_UPDATE = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_VAR    = 7'b0010000,
    S_SQRT   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [WLEN_W-1:0]     window_len_r;
  logic [PW-1:0]         wpos_r;
  logic [LW-1:0]         fill_r;
  logic [SW-1:0]         sum_r;
  logic [SQW-1:0]        sq_r;
  logic [PRICE_BITS-1:0] price_r;
  logic                  evict_r;
  logic [CNT_W-1:0]      cnt_r;

  logic [PRICE_BITS-1:0] ring [MAX_WINDOW];
  logic [PRICE_BITS-1:0] rd_data_r;

  logic [DW-1:0]         ds_r, dsq_r;
  logic [LW-1:0]         rem_s_r, rem_q_r;
  logic [VW-1:0]         mm_r;
  logic [VW-1:0]         v_r, root_r, bit_r;

  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_mean_r, out_sd_r;
  logic [BAND_W-1:0]     out_upper_r, out_lower_r;
  logic                  out_full_r;

  logic [LW-1:0]         eff_len;
  logic                  in_fire, cfg_wr, cfg_sel;
  logic [PW-1:0]         base_wpos, old_addr, wpos_inc;
  logic [LW-1:0]         base_fill;
  logic                  evict;
  logic [LW:0]           old_tmp;
  logic [VW-1:0]         pp, qq;
  logic [SW-1:0]         sum_nxt;
  logic [SQW-1:0]        sq_nxt;
  logic [LW:0]           s1_s, s2_s, s1_q, s2_q;
  logic [VW-1:0]         meansq, rb_sum;
  logic [OUT_W-1:0]      mean24, sd24;
  logic [BAND_W-1:0]     two_sd;
  logic                  out_load;

  // One restoring division step on the narrow remainder.
  function automatic logic [LW:0] div_step(input logic [LW-1:0] rem, input logic b,
                                           input logic [LW-1:0] n);
    logic [LW:0] t;
    t = {rem, b};
    if (t >= {1'b0, n}) begin
      div_step = {1'b1, LW'(t - {1'b0, n})};
    end else begin
      div_step = {1'b0, t[LW-1:0]};
    end
  endfunction

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_sel  = (paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LEN);
  assign prdata   = cfg_sel ? CFG_DATA_W'(window_len_r) : '0;

  // A length of zero counts as one, anything beyond the ring as the ring size.
  always_comb begin
    if (window_len_r == '0) begin
      eff_len = LW'(1);
    end else if (32'(window_len_r) > MAX_WINDOW) begin
      eff_len = LW'(MAX_WINDOW);
    end else begin
      eff_len = LW'(window_len_r);
    end
  end

  always_comb begin
    base_wpos = in_chan.restart ? '0 : wpos_r;
    base_fill = in_chan.restart ? '0 : fill_r;
    evict     = (base_fill >= eff_len);
    wpos_inc  = (32'(base_wpos) == MAX_WINDOW - 1) ? '0 : PW'(base_wpos + 1'b1);
    if ((LW + 1)'(wpos_r) >= (LW + 1)'(eff_len)) begin
      old_tmp = (LW + 1)'(wpos_r) - (LW + 1)'(eff_len);
    end else begin
      old_tmp = (LW + 1)'(wpos_r) + (LW + 1)'(MAX_WINDOW) - (LW + 1)'(eff_len);
    end
    old_addr = PW'(old_tmp);
  end

  always_comb begin
    pp      = {{PRICE_BITS{1'b0}}, price_r} * {{PRICE_BITS{1'b0}}, price_r};
    qq      = {{PRICE_BITS{1'b0}}, rd_data_r} * {{PRICE_BITS{1'b0}}, rd_data_r};
    sum_nxt = sum_r - (evict_r ? SW'(rd_data_r) : '0) + SW'(price_r);
    sq_nxt  = sq_r - (evict_r ? SQW'(qq) : '0) + SQW'(pp);
  end

  always_comb begin
    s1_s = div_step(rem_s_r, ds_r[DW-1], fill_r);
    s2_s = div_step(s1_s[LW-1:0], ds_r[DW-2], fill_r);
    s1_q = div_step(rem_q_r, dsq_r[DW-1], fill_r);
    s2_q = div_step(s1_q[LW-1:0], dsq_r[DW-2], fill_r);
    meansq = dsq_r[VW-1:0];
    rb_sum = root_r + bit_r;
  end

  always_comb begin
    mean24   = OUT_W'(ds_r[PRICE_BITS-1:0]);
    sd24     = (64'(root_r) > 64'(OUT_MAX)) ? OUT_MAX : OUT_W'(root_r);
    two_sd   = {1'b0, sd24, 1'b0};
    out_load = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_DIV;
      S_DIV:    if (cnt_r == CNT_W'(1)) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_VAR;
      S_VAR:    state_nxt = S_SQRT;
      S_SQRT:   if (cnt_r == CNT_W'(1)) state_nxt = S_OUT;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Ring memory: the evicted price is read on the same edge that the new one
  // is written, and a read of the written entry returns the old contents.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring[base_wpos] <= in_chan.price;
      rd_data_r       <= ring[old_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      window_len_r <= WLEN_RESET;
      wpos_r       <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      sq_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_sel) begin
        window_len_r <= pwdata[WLEN_W-1:0];
        wpos_r       <= '0;
        fill_r       <= '0;
        sum_r        <= '0;
        sq_r         <= '0;
      end else if (in_fire) begin
        wpos_r <= wpos_inc;
        fill_r <= evict ? eff_len : LW'(base_fill + 1'b1);
        if (in_chan.restart) begin
          sum_r <= '0;
          sq_r  <= '0;
        end
      end else if (state_r == S_UPDATE) begin
        sum_r <= sum_nxt;
        sq_r  <= sq_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        price_r <= in_chan.price;
        evict_r <= evict;
      end
      S_UPDATE: begin
        ds_r    <= DW'(sum_nxt);
        dsq_r   <= DW'(sq_nxt);
        rem_s_r <= '0;
        rem_q_r <= '0;
        cnt_r   <= CNT_W'(DIT);
      end
      S_DIV: begin
        ds_r    <= {ds_r[DW-3:0], s1_s[LW], s2_s[LW]};
        dsq_r   <= {dsq_r[DW-3:0], s1_q[LW], s2_q[LW]};
        rem_s_r <= s2_s[LW-1:0];
        rem_q_r <= s2_q[LW-1:0];
        cnt_r   <= cnt_r - 1'b1;
      end
      S_MUL: begin
        mm_r <= {{PRICE_BITS{1'b0}}, ds_r[PRICE_BITS-1:0]} *
                {{PRICE_BITS{1'b0}}, ds_r[PRICE_BITS-1:0]};
      end
      S_VAR: begin
        v_r    <= (meansq > mm_r) ? (meansq - mm_r) : '0;
        root_r <= '0;
        bit_r  <= {2'b01, {(VW - 2){1'b0}}};
        cnt_r  <= CNT_W'(SIT);
      end
      S_SQRT: begin
        if (v_r >= rb_sum) begin
          v_r    <= v_r - rb_sum;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
      end
      S_OUT: begin
        if (out_load) begin
          out_mean_r  <= mean24;
          out_sd_r    <= sd24;
          out_upper_r <= {2'b00, mean24} + two_sd;
          out_lower_r <= {2'b00, mean24} - two_sd;
          out_full_r  <= (fill_r >= eff_len);
        end
      end
      default: begin
        price_r <= price_r;
      end
    endcase
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.mean        = out_mean_r;
  assign out_chan.std_dev     = out_sd_r;
  assign out_chan.upper_band  = out_upper_r;
  assign out_chan.lower_band  = signed'(out_lower_r);
  assign out_chan.window_full = out_full_r;

  `MWBB_ASSERT_IMP(a_fill_in_range, 1'b1, fill_r <= eff_len)
  `MWBB_ASSERT_IMP(a_rem_below_n, state_r == S_DIV, (rem_s_r < fill_r) && (rem_q_r < fill_r))
  `MWBB_ASSERT_NXT(a_accept_starts_update, in_fire, state_r == S_UPDATE && fill_r != '0)
  `MWBB_ASSERT_NXT(a_cfg_clears_window, cfg_wr && cfg_sel, fill_r == '0 && wpos_r == '0)
  `MWBB_ASSERT_NXT(a_result_loaded, out_load, out_valid_r && state_r == S_IDLE)

endmodule
